// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned TOP_ORDER_DEF  = 5;
  localparam int unsigned NUM_FRAMES_DEF = 32768;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } bpa_mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ORDER = 3'd1,
    ST_NO_BLOCK  = 3'd2,
    ST_ALREADY   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_NOT_INIT  = 3'd5
  } bpa_status_e;

  // register indexes of the configuration port
  localparam logic [0:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [0:0] REG_RANGE_PAGES  = 1'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  block_order;
    logic [31:0] block_address;
  } bpa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [2:0]  granted_order;
    logic [15:0] pages_in_use;
  } bpa_rsp_t;

  // page map control: clear sweep write, word read, read-modify-write, set or clear
  typedef struct packed {
    logic clr;
    logic rd;
    logic upd;
    logic set;
  } bpa_map_ctl_t;

  // first slot of an order in the flat block table
  function automatic int unsigned order_base(int unsigned nf, int unsigned k);
    int unsigned off;
    off = 0;
    for (int unsigned j = 0; j < 6; j++) begin
      if (j < k) off += nf >> j;
    end
    return off;
  endfunction

endpackage

// ===== rtl/bpa_page_map.sv =====
// ----------------------------------------------------------------------------
// bpa_page_map
// Allocated-page bitmap, one word per 32 pages, with block mask and count.
// ----------------------------------------------------------------------------
module bpa_page_map import bpa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  localparam int unsigned IW  = $clog2(NUM_FRAMES),
  localparam int unsigned MW  = (NUM_FRAMES + 31) / 32,
  localparam int unsigned MAB = $clog2(MW)
) (
  input  logic               clk_i,
  input  bpa_map_ctl_t       ctl_i,
  input  logic [MAB-1:0]     clr_addr_i,
  input  logic [IW-1:0]      page_i,
  input  logic [2:0]         order_i,
  output logic               hit_o,
  output logic [5:0]         delta_o
);

  logic [31:0] map_mem [MW];
  logic [31:0] rdata_q;
  logic [31:0] mask;
  logic [5:0]  n_pages;
  logic [MAB-1:0] waddr;

  assign waddr   = MAB'(page_i >> 5);
  assign n_pages = 6'(6'd1 << order_i);
  // a shift by 32 leaves zero, so a full word comes out all ones
  assign mask    = (~(32'hFFFF_FFFF << n_pages)) << page_i[4:0];
  assign hit_o   = |(rdata_q & mask);
  assign delta_o = ctl_i.set ? 6'($countones(mask & ~rdata_q))
                             : 6'($countones(mask & rdata_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      map_mem[clr_addr_i] <= '0;
    end else if (ctl_i.upd) begin
      map_mem[waddr] <= ctl_i.set ? (rdata_q | mask) : (rdata_q & ~mask);
    end
    if (ctl_i.rd) rdata_q <= map_mem[waddr];
  end

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a page range, orders 0 to TOP_ORDER, with FIFO free
// lists kept in a block table memory and an allocated-page bitmap.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   start_i, req_i, busy_o             taken when start_i & !busy_o
//  result    done_o, rsp_o                      one-cycle strobe, no stall
//  config    cfg_we_i, cfg_addr_i, cfg_wdata_i  written when cfg_we_i
//
// one item at a time through a sequencer on a single-port block table
// list inserts and removals run as subsequences, each returning to its caller
// allocate: with or without a split, at most from order 5 down to order 0
// free: with or without a merge chain, at most from order 0 up to order 5
// initialize: clears 2*NUM_FRAMES slots, then inserts each block in its list
// after reset the block is idle at once; results cannot be held off
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned TOP_ORDER  = TOP_ORDER_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  bpa_req_t    req_i,
  output logic        done_o,
  output bpa_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned IW    = $clog2(NUM_FRAMES);
  localparam int unsigned SW    = IW + 1;
  localparam int unsigned HPW   = IW + 1;
  localparam int unsigned KW    = (TOP_ORDER < 2) ? 1 : $clog2(TOP_ORDER + 1);
  localparam int unsigned SLOTS = 2 * NUM_FRAMES;
  localparam int unsigned MW    = (NUM_FRAMES + 31) / 32;
  localparam int unsigned MAB   = $clog2(MW);
  localparam int unsigned PSH   = $clog2(PAGE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_INIT_LOOP, S_SPLIT, S_MAP_RD, S_MAP_UPD,
    S_FREE_RDMAP, S_FREE_CHK, S_MERGE, S_MERGE_RB, S_MERGE_EVAL,
    S_MERGE_DEL2, S_MERGE_UP, S_ADD_RD, S_ADD_EVAL, S_ADD_LINK,
    S_DEL_RD, S_DEL_EVAL, S_DEL_NEXT, S_DEL_PREV
  } state_e;

  typedef struct packed {
    logic          avail;
    logic [IW-1:0] nxt;
    logic [IW-1:0] prv;
  } slot_t;

  // block table: free flag and list links per slot
  slot_t slot_mem [SLOTS];
  slot_t sm_rdata_q;
  slot_t sm_wdata;
  logic [SW-1:0] sm_addr;
  logic sm_re, sm_we_flag, sm_we_next, sm_we_prev;

  state_e state_q, ret_q;
  logic [31:0]    base_q, held_base_q;
  logic [15:0]    range_q;
  logic [HPW-1:0] held_pages_q;
  logic           ready_q;
  logic [15:0]    used_q;
  logic [IW-1:0]  head_q [TOP_ORDER+1];
  logic [IW-1:0]  tail_q [TOP_ORDER+1];
  logic [IW:0]    cnt_q  [TOP_ORDER+1];
  logic [KW-1:0]  sub_k_q, k_q, ord_q;
  logic [IW-1:0]  sub_idx_q, idx_q, del_p_q, del_n_q, page_q;
  logic [HPW-1:0] init_page_q;
  logic [1:0]     ph_q;
  logic           is_alloc_q, flag_a_q;
  logic [SW-1:0]  clr_cnt_q;
  logic           done_q;
  bpa_rsp_t       rsp_q;

  bpa_map_ctl_t map_ctl;
  logic         map_hit;
  logic [5:0]   map_delta;

  function automatic logic [SW-1:0] slot_addr(logic [KW-1:0] k, logic [IW-1:0] idx);
    return SW'(order_base(NUM_FRAMES, 32'(k))) + SW'(idx);
  endfunction

  // smallest non-empty order at or above the requested one
  logic          fnd;
  logic [KW-1:0] fnd_k;
  always_comb begin
    fnd   = 1'b0;
    fnd_k = '0;
    for (int j = TOP_ORDER; j >= 0; j--) begin
      if (j >= int'(req_i.block_order) && cnt_q[j] != '0) begin
        fnd   = 1'b1;
        fnd_k = KW'(j);
      end
    end
  end

  // free request page, rounded down to the block boundary
  logic [31:0] n32, pg32, hp32;
  logic        out_of_range;
  assign n32  = 32'd1 << req_i.block_order;
  assign pg32 = ((req_i.block_address - held_base_q) >> PSH) & ~(n32 - 32'd1);
  assign hp32 = 32'(held_pages_q);
  assign out_of_range = (pg32 >= hp32) || ((hp32 - pg32) < n32);

  logic [HPW-1:0] init_sz;
  logic [HPW-1:0] nf_pages;
  logic [IW-1:0]  buddy;
  assign init_sz  = HPW'(1) << k_q;
  assign nf_pages = HPW'(NUM_FRAMES);
  assign buddy    = idx_q ^ IW'(1);

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // block table port
  always_comb begin
    sm_addr    = slot_addr(sub_k_q, sub_idx_q);
    sm_re      = 1'b0;
    sm_we_flag = 1'b0;
    sm_we_next = 1'b0;
    sm_we_prev = 1'b0;
    sm_wdata   = '0;
    unique case (state_q)
      S_CLR: begin
        sm_addr    = clr_cnt_q;
        sm_we_flag = 1'b1;
        sm_we_next = 1'b1;
        sm_we_prev = 1'b1;
      end
      S_ADD_RD, S_DEL_RD: sm_re = 1'b1;
      S_ADD_EVAL: begin
        if (!sm_rdata_q.avail) begin
          sm_we_flag     = 1'b1;
          sm_we_next     = 1'b1;
          sm_we_prev     = 1'b1;
          sm_wdata.avail = 1'b1;
          sm_wdata.prv   = tail_q[sub_k_q];
        end
      end
      S_ADD_LINK: begin
        sm_addr      = slot_addr(sub_k_q, tail_q[sub_k_q]);
        sm_we_next   = 1'b1;
        sm_wdata.nxt = sub_idx_q;
      end
      S_DEL_EVAL: sm_we_flag = sm_rdata_q.avail;
      S_DEL_NEXT: begin
        sm_addr      = slot_addr(sub_k_q, del_p_q);
        sm_we_next   = (head_q[sub_k_q] != sub_idx_q);
        sm_wdata.nxt = del_n_q;
      end
      S_DEL_PREV: begin
        sm_addr      = slot_addr(sub_k_q, del_n_q);
        sm_we_prev   = (tail_q[sub_k_q] != sub_idx_q);
        sm_wdata.prv = del_p_q;
      end
      S_MERGE: begin
        sm_addr = slot_addr(k_q, idx_q);
        sm_re   = 1'b1;
      end
      S_MERGE_RB: begin
        sm_addr = slot_addr(k_q, buddy);
        sm_re   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sm_we_flag) slot_mem[sm_addr].avail <= sm_wdata.avail;
    if (sm_we_next) slot_mem[sm_addr].nxt   <= sm_wdata.nxt;
    if (sm_we_prev) slot_mem[sm_addr].prv   <= sm_wdata.prv;
    if (sm_re)      sm_rdata_q <= slot_mem[sm_addr];
  end

  always_comb begin
    map_ctl     = '0;
    map_ctl.set = is_alloc_q;
    map_ctl.clr = (state_q == S_CLR) && (32'(clr_cnt_q) < MW);
    map_ctl.rd  = (state_q == S_FREE_RDMAP) || (state_q == S_MAP_RD);
    map_ctl.upd = (state_q == S_MAP_UPD);
  end

  bpa_page_map #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_map (
    .clk_i      (clk_i),
    .ctl_i      (map_ctl),
    .clr_addr_i (clr_cnt_q[MAB-1:0]),
    .page_i     (page_q),
    .order_i    (3'(ord_q)),
    .hit_o      (map_hit),
    .delta_o    (map_delta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      base_q       <= '0;
      range_q      <= 16'd32768;
      held_base_q  <= '0;
      held_pages_q <= '0;
      ready_q      <= 1'b0;
      used_q       <= '0;
      for (int j = 0; j <= TOP_ORDER; j++) begin
        head_q[j] <= '0;
        tail_q[j] <= '0;
        cnt_q[j]  <= '0;
      end
      sub_k_q     <= '0;
      sub_idx_q   <= '0;
      k_q         <= '0;
      ord_q       <= '0;
      idx_q       <= '0;
      del_p_q     <= '0;
      del_n_q     <= '0;
      page_q      <= '0;
      init_page_q <= '0;
      ph_q        <= '0;
      is_alloc_q  <= 1'b0;
      flag_a_q    <= 1'b0;
      clr_cnt_q   <= '0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_BASE_ADDRESS: base_q  <= cfg_wdata_i;
          REG_RANGE_PAGES:  range_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rsp_q <= '{status: ST_OK, granted_address: '0, granted_order: '0,
                       pages_in_use: used_q};
            unique case (bpa_mode_e'(req_i.mode))
              MODE_INIT: begin
                held_base_q  <= base_q;
                held_pages_q <= ({1'b0, range_q} < 17'(NUM_FRAMES)) ?
                                HPW'(range_q) : nf_pages;
                for (int j = 0; j <= TOP_ORDER; j++) begin
                  head_q[j] <= '0;
                  tail_q[j] <= '0;
                  cnt_q[j]  <= '0;
                end
                used_q      <= '0;
                clr_cnt_q   <= '0;
                init_page_q <= '0;
                k_q         <= KW'(TOP_ORDER);
                state_q     <= S_CLR;
              end
              MODE_ALLOC, MODE_FREE: begin
                ord_q      <= KW'(req_i.block_order);
                is_alloc_q <= (req_i.mode == MODE_ALLOC);
                if (!ready_q) begin
                  rsp_q.status <= ST_NOT_INIT;
                  done_q       <= 1'b1;
                end else if (32'(req_i.block_order) > TOP_ORDER) begin
                  rsp_q.status <= ST_BAD_ORDER;
                  done_q       <= 1'b1;
                end else if (req_i.mode == MODE_ALLOC) begin
                  if (!fnd) begin
                    rsp_q.status <= ST_NO_BLOCK;
                    done_q       <= 1'b1;
                  end else begin
                    k_q     <= fnd_k;
                    ph_q    <= '0;
                    state_q <= S_SPLIT;
                  end
                end else if (out_of_range) begin
                  rsp_q.status <= ST_RANGE;
                  done_q       <= 1'b1;
                end else begin
                  page_q  <= IW'(pg32);
                  state_q <= S_FREE_RDMAP;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + SW'(1);
          if (clr_cnt_q == SW'(SLOTS - 1)) state_q <= S_INIT_LOOP;
        end
        S_INIT_LOOP: begin
          if (held_pages_q - init_page_q >= init_sz) begin
            sub_k_q     <= k_q;
            sub_idx_q   <= IW'(init_page_q >> k_q);
            init_page_q <= init_page_q + init_sz;
            ret_q       <= S_INIT_LOOP;
            state_q     <= S_ADD_RD;
          end else if (k_q == '0) begin
            ready_q            <= 1'b1;
            rsp_q.pages_in_use <= '0;
            done_q             <= 1'b1;
            state_q            <= S_IDLE;
          end else begin
            k_q <= k_q - KW'(1);
          end
        end
        // split the head of order k down, lower half queued first
        S_SPLIT: begin
          unique case (ph_q)
            2'd0: begin
              sub_k_q   <= k_q;
              sub_idx_q <= head_q[k_q];
              idx_q     <= head_q[k_q];
              state_q   <= S_DEL_RD;
              if (k_q == ord_q) begin
                page_q <= IW'(head_q[k_q] << k_q);
                ret_q  <= S_MAP_RD;
              end else begin
                ret_q <= S_SPLIT;
                ph_q  <= 2'd1;
              end
            end
            2'd1: begin
              sub_k_q   <= k_q - KW'(1);
              sub_idx_q <= IW'(idx_q << 1);
              ph_q      <= 2'd2;
              state_q   <= S_ADD_RD;
            end
            default: begin
              sub_k_q   <= k_q - KW'(1);
              sub_idx_q <= IW'(idx_q << 1) | IW'(1);
              k_q       <= k_q - KW'(1);
              ph_q      <= 2'd0;
              state_q   <= S_ADD_RD;
            end
          endcase
        end
        S_FREE_RDMAP: state_q <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (!map_hit) begin
            rsp_q.status <= ST_ALREADY;
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            k_q       <= ord_q;
            idx_q     <= page_q >> ord_q;
            sub_k_q   <= ord_q;
            sub_idx_q <= page_q >> ord_q;
            ret_q     <= S_MERGE;
            state_q   <= S_ADD_RD;
          end
        end
        S_MERGE: begin
          if (32'(k_q) >= TOP_ORDER || 32'(buddy) >= (32'(NUM_FRAMES) >> k_q)) begin
            state_q <= S_MAP_RD;
          end else begin
            state_q <= S_MERGE_RB;
          end
        end
        S_MERGE_RB: begin
          flag_a_q <= sm_rdata_q.avail;
          state_q  <= S_MERGE_EVAL;
        end
        S_MERGE_EVAL: begin
          if (flag_a_q && sm_rdata_q.avail) begin
            sub_k_q   <= k_q;
            sub_idx_q <= idx_q;
            ret_q     <= S_MERGE_DEL2;
            state_q   <= S_DEL_RD;
          end else begin
            state_q <= S_MAP_RD;
          end
        end
        S_MERGE_DEL2: begin
          sub_idx_q <= buddy;
          ret_q     <= S_MERGE_UP;
          state_q   <= S_DEL_RD;
        end
        S_MERGE_UP: begin
          k_q       <= k_q + KW'(1);
          idx_q     <= idx_q >> 1;
          sub_k_q   <= k_q + KW'(1);
          sub_idx_q <= idx_q >> 1;
          ret_q     <= S_MERGE;
          state_q   <= S_ADD_RD;
        end
        S_MAP_RD: state_q <= S_MAP_UPD;
        S_MAP_UPD: begin
          if (is_alloc_q) begin
            used_q                <= used_q + 16'(map_delta);
            rsp_q.pages_in_use    <= used_q + 16'(map_delta);
            rsp_q.granted_address <= held_base_q + (32'(page_q) << PSH);
            rsp_q.granted_order   <= 3'(ord_q);
          end else begin
            used_q             <= used_q - 16'(map_delta);
            rsp_q.pages_in_use <= used_q - 16'(map_delta);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        // list insert at the tail, skipped when already queued
        S_ADD_RD: state_q <= S_ADD_EVAL;
        S_ADD_EVAL: begin
          if (sm_rdata_q.avail) begin
            state_q <= ret_q;
          end else if (cnt_q[sub_k_q] != '0) begin
            state_q <= S_ADD_LINK;
          end else begin
            head_q[sub_k_q] <= sub_idx_q;
            tail_q[sub_k_q] <= sub_idx_q;
            cnt_q[sub_k_q]  <= cnt_q[sub_k_q] + 1'b1;
            state_q         <= ret_q;
          end
        end
        S_ADD_LINK: begin
          tail_q[sub_k_q] <= sub_idx_q;
          cnt_q[sub_k_q]  <= cnt_q[sub_k_q] + 1'b1;
          state_q         <= ret_q;
        end
        // list removal, skipped when not queued
        S_DEL_RD: state_q <= S_DEL_EVAL;
        S_DEL_EVAL: begin
          del_p_q <= sm_rdata_q.prv;
          del_n_q <= sm_rdata_q.nxt;
          state_q <= sm_rdata_q.avail ? S_DEL_NEXT : ret_q;
        end
        S_DEL_NEXT: begin
          if (head_q[sub_k_q] == sub_idx_q) head_q[sub_k_q] <= del_n_q;
          state_q <= S_DEL_PREV;
        end
        S_DEL_PREV: begin
          if (tail_q[sub_k_q] == sub_idx_q) tail_q[sub_k_q] <= del_p_q;
          cnt_q[sub_k_q] <= cnt_q[sub_k_q] - 1'b1;
          state_q        <= ret_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
